// ===== src/assembly_token_classifier_defines.svh =====
// Assertion macros for the token classifier checker.
`ifndef ASSEMBLY_TOKEN_CLASSIFIER_DEFINES_SVH
`define ASSEMBLY_TOKEN_CLASSIFIER_DEFINES_SVH

// Property that must hold on every rising clock edge outside reset.
`define ATC_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define ATC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/atc_pkg.sv =====
`timescale 1ns / 1ps
package atc_pkg;

  localparam int unsigned LineWidthDef   = 20;
  localparam int unsigned ColumnWidthDef = 16;
  localparam int unsigned LengthWidthDef = 8;

  // Token classes
  localparam logic [4:0] TypeUndef   = 5'd0;
  localparam logic [4:0] TypePreproc = 5'd1;
  localparam logic [4:0] TypeDec     = 5'd2;
  localparam logic [4:0] TypeHex     = 5'd3;
  localparam logic [4:0] TypeInstr   = 5'd4;
  localparam logic [4:0] TypeReg     = 5'd5;
  localparam logic [4:0] TypeCurly   = 5'd6;
  localparam logic [4:0] TypeSquare  = 5'd10;
  localparam logic [4:0] TypeLabel   = 5'd14;
  localparam logic [4:0] TypeLblRd   = 5'd15;
  localparam logic [4:0] TypeLblWr   = 5'd16;

  // Number recognizer
  localparam logic [2:0] NStart = 3'd0;
  localparam logic [2:0] NMinus = 3'd1;
  localparam logic [2:0] NZero  = 3'd2;
  localparam logic [2:0] NDec   = 3'd3;
  localparam logic [2:0] NX     = 3'd4;
  localparam logic [2:0] NHex   = 3'd5;
  localparam logic [2:0] NDead  = 3'd6;

  // Bracket recognizer
  localparam logic [3:0] BStart = 4'd0;
  localparam logic [3:0] BOpen  = 4'd1;
  localparam logic [3:0] BZero  = 4'd2;
  localparam logic [3:0] BDec   = 4'd3;
  localparam logic [3:0] BX     = 4'd4;
  localparam logic [3:0] BHex   = 4'd5;
  localparam logic [3:0] BCDec  = 4'd6;
  localparam logic [3:0] BCHex  = 4'd7;
  localparam logic [3:0] BGDec  = 4'd8;
  localparam logic [3:0] BAHex  = 4'd9;
  localparam logic [3:0] BDead  = 4'd15;

  // Register recognizer
  localparam logic [1:0] RStart = 2'd0;
  localparam logic [1:0] RLet   = 2'd1;
  localparam logic [1:0] RDig   = 2'd2;
  localparam logic [1:0] RDead  = 2'd3;

  localparam logic [5:0] NodeRoot = 6'd0;
  localparam logic [5:0] NodeDead = 6'd63;

  // Recognizer state of the open token
  typedef struct packed {
    logic [2:0] num;
    logic [3:0] brk;
    logic       curly;
    logic [1:0] rgs;
    logic       first_pct;
    logic [1:0] first_open;
    logic [1:0] last_close;
    logic [5:0] node;
    logic       colon;
  } prog_t;

  // Item handed from the front to the back
  typedef struct packed {
    prog_t      prog;
    logic       len_ge3;
  } ev_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic is_tok(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || is_digit(c) || c == 8'h25 || c == 8'h24 ||
           c == 8'h3a || c == 8'h5b || c == 8'h5d || c == 8'h7b || c == 8'h7d ||
           c == 8'h2d;
  endfunction

  function automatic logic [2:0] num_next(input logic [2:0] st, input logic [7:0] c);
    logic [2:0] r;
    r = NDead;
    case (st)
      NStart: begin
        if (c == 8'h2d) r = NMinus;
        else if (c == 8'h30) r = NZero;
        else if (is_digit(c)) r = NDec;
      end
      NMinus: begin
        if (c == 8'h30) r = NZero;
        else if (is_digit(c)) r = NDec;
      end
      NZero: begin
        if (c == 8'h78) r = NX;
        else if (is_digit(c)) r = NDec;
      end
      NDec: if (is_digit(c)) r = NDec;
      NX, NHex: if (is_hex(c)) r = NHex;
      default: r = NDead;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] brk_next(input logic [3:0] st, input logic curly,
                                          input logic [7:0] c);
    logic [3:0] r;
    logic [7:0] cl;
    cl = curly ? 8'h7d : 8'h5d;
    r = BDead;
    case (st)
      BStart: if (c == 8'h7b || c == 8'h5b) r = BOpen;
      BOpen: begin
        if (c == 8'h30) r = BZero;
        else if (is_digit(c)) r = BDec;
      end
      BZero: begin
        if (c == 8'h78) r = BX;
        else if (c == cl) r = BCDec;
        else if (is_digit(c)) r = BDec;
      end
      BDec: begin
        if (c == cl) r = BCDec;
        else if (is_digit(c)) r = BDec;
      end
      BX: if (is_hex(c)) r = BHex;
      BHex: begin
        if (c == cl) r = BCHex;
        else if (is_hex(c)) r = BHex;
      end
      BCDec: if (c == 8'h67) r = BGDec;
      BCHex: if (c == 8'h61) r = BAHex;
      default: r = BDead;
    endcase
    return r;
  endfunction

  // Keyword trie: node numbers follow the prefix list; returns the next node.
  function automatic logic [5:0] trie_next(input logic [5:0] n, input logic [7:0] c);
    logic [5:0] r;
    r = NodeDead;
    case (n)
      6'd0: case (c)
        8'h68: r = 6'd1;  8'h6d: r = 6'd4;  8'h73: r = 6'd7;  8'h63: r = 6'd11;
        8'h70: r = 6'd17; 8'h6a: r = 6'd28; 8'h72: r = 6'd38; 8'h69: r = 6'd41;
        default: r = NodeDead;
      endcase
      6'd1:  if (c == 8'h6c) r = 6'd2;
      6'd2:  if (c == 8'h74) r = 6'd3;
      6'd4:  if (c == 8'h6f) r = 6'd5;
      6'd5:  if (c == 8'h76) r = 6'd6;
      6'd7:  if (c == 8'h75) r = 6'd8;
      6'd8: begin
        if (c == 8'h6d) r = 6'd9;
        else if (c == 8'h62) r = 6'd10;
      end
      6'd11: begin
        if (c == 8'h6d) r = 6'd12;
        else if (c == 8'h61) r = 6'd14;
      end
      6'd12: if (c == 8'h70) r = 6'd13;
      6'd14: if (c == 8'h6c) r = 6'd15;
      6'd15: if (c == 8'h6c) r = 6'd16;
      6'd17: begin
        if (c == 8'h75) r = 6'd18;
        else if (c == 8'h6f) r = 6'd26;
      end
      6'd18: if (c == 8'h73) r = 6'd19;
      6'd19: if (c == 8'h68) r = 6'd20;
      6'd20: case (c)
        8'h62: r = 6'd21; 8'h73: r = 6'd22; 8'h69: r = 6'd23; 8'h6c: r = 6'd24;
        8'h72: r = 6'd25;
        default: r = NodeDead;
      endcase
      6'd26: if (c == 8'h70) r = 6'd27;
      6'd28: case (c)
        8'h6d: r = 6'd29; 8'h65: r = 6'd31; 8'h6c: r = 6'd32; 8'h62: r = 6'd33;
        8'h6e: r = 6'd34;
        default: r = NodeDead;
      endcase
      6'd29: if (c == 8'h70) r = 6'd30;
      6'd32: if (c == 8'h65) r = 6'd36;
      6'd33: if (c == 8'h65) r = 6'd37;
      6'd34: if (c == 8'h65) r = 6'd35;
      6'd38: if (c == 8'h65) r = 6'd39;
      6'd39: if (c == 8'h74) r = 6'd40;
      6'd41: begin
        if (c == 8'h6e) r = 6'd42;
        else if (c == 8'h72) r = 6'd44;
      end
      6'd42: if (c == 8'h74) r = 6'd43;
      6'd44: if (c == 8'h65) r = 6'd45;
      6'd45: if (c == 8'h74) r = 6'd46;
      default: r = NodeDead;
    endcase
    return r;
  endfunction

  function automatic logic trie_kw(input logic [5:0] n);
    logic k;
    case (n)
      6'd3, 6'd6, 6'd9, 6'd10, 6'd13, 6'd16, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24,
      6'd25, 6'd27, 6'd30, 6'd31, 6'd32, 6'd33, 6'd35, 6'd36, 6'd37, 6'd40,
      6'd43, 6'd46: k = 1'b1;
      default: k = 1'b0;
    endcase
    return k;
  endfunction

endpackage

// ===== src/assembly_token_classifier.sv =====
`timescale 1ns / 1ps
// A token result reaches the outputs after the transfer of the byte that ends it,
// through the queue write, registered queue read and classify output register.
// Throughput: one byte per cycle while full is low; the recognizers step on each byte.
// full rises while three tokens wait in the 4-entry token queue. Reset (rst_ni low,
// asynchronous) empties the queue and returns counters to line 1, column 1.
module assembly_token_classifier import atc_pkg::*; #(
  parameter int unsigned LineWidth   = LineWidthDef,
  parameter int unsigned ColumnWidth = ColumnWidthDef,
  parameter int unsigned LengthWidth = LengthWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             ch_i,
  input  logic                   text_end_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [4:0]             token_type_o,
  output logic [LineWidth-1:0]   token_line_o,
  output logic [ColumnWidth-1:0] token_column_o,
  output logic [LengthWidth-1:0] token_length_o
);
  localparam int unsigned Depth = 4;
  localparam int unsigned AW    = $clog2(Depth);
  localparam int unsigned PW    = LineWidth + ColumnWidth + LengthWidth;
  localparam int unsigned EW    = $bits(ev_t);

  logic                   ev_valid;
  ev_t                    ev, q_ev;
  logic [LineWidth-1:0]   ev_line;
  logic [ColumnWidth-1:0] ev_col;
  logic [LengthWidth-1:0] ev_len;
  logic [AW-1:0]          wr_q, rd_q;
  logic [AW:0]            cnt_q;
  logic                   wr, rd, bvalid, bready;
  logic                   ev_ram_rd, pos_rd;
  logic [EW-1:0]          ev_rdata;
  logic [PW-1:0]          pos_rdata, pos_q;
  logic                   rv_q;
  logic                   back_valid;

  atc_front #(.LineWidth(LineWidth), .ColumnWidth(ColumnWidth),
              .LengthWidth(LengthWidth)) u_front (
    .clk_i, .rst_ni, .valid_i(push && !full), .ch_i, .text_end_i,
    .ev_valid_o(ev_valid), .ev_o(ev), .ev_line_o(ev_line), .ev_col_o(ev_col),
    .ev_len_o(ev_len)
  );

  // Token queue: registered-read RAM with a one-entry read stage
  assign full = cnt_q >= (AW+1)'(Depth - 1);
  assign wr = push && !full && ev_valid;
  assign rd = (cnt_q != '0) && (!rv_q || bready);
  assign bvalid = rv_q;

  atc_ram #(.Width(EW), .Depth(Depth)) u_ev_ram (
    .clk_i, .we_i(wr), .waddr_i(wr_q), .wdata_i(ev),
    .re_i(ev_ram_rd), .raddr_i(rd_q), .rdata_o(ev_rdata)
  );
  atc_ram #(.Width(PW), .Depth(Depth)) u_pos_ram (
    .clk_i, .we_i(wr), .waddr_i(wr_q), .wdata_i({ev_line, ev_col, ev_len}),
    .re_i(pos_rd), .raddr_i(rd_q), .rdata_o(pos_rdata)
  );
  assign ev_ram_rd = rd;
  assign pos_rd = rd;
  assign q_ev = ev_t'(ev_rdata);

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
      rv_q <= 1'b0;
    end else begin
      if (wr) wr_q <= wr_q + 1'b1;
      if (ev_ram_rd) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(pos_rd);
      if (rd) rv_q <= 1'b1;
      else if (bready) rv_q <= 1'b0;
    end
  end

  atc_back u_back (
    .clk_i, .rst_ni, .valid_i(bvalid), .ev_i(q_ev), .ready_o(bready),
    .valid_o(back_valid), .pop_i(pop), .type_o(token_type_o)
  );

  // Hold position fields alongside the class
  always_ff @(posedge clk_i) begin
    if (bready && bvalid) pos_q <= pos_rdata;
  end

  assign empty = !back_valid;
  assign {token_line_o, token_column_o, token_length_o} = pos_q;
endmodule

// ===== src/atc_ram.sv =====
`timescale 1ns / 1ps
module atc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read; hold read data between reads
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== src/atc_front.sv =====
`timescale 1ns / 1ps
module atc_front import atc_pkg::*; #(
  parameter int unsigned LineWidth   = LineWidthDef,
  parameter int unsigned ColumnWidth = ColumnWidthDef,
  parameter int unsigned LengthWidth = LengthWidthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic [7:0]             ch_i,
  input  logic                   text_end_i,
  output logic                   ev_valid_o,
  output ev_t                    ev_o,
  output logic [LineWidth-1:0]   ev_line_o,
  output logic [ColumnWidth-1:0] ev_col_o,
  output logic [LengthWidth-1:0] ev_len_o
);
  localparam logic [LineWidth-1:0]   LineTop = '1;
  localparam logic [ColumnWidth-1:0] ColTop  = '1;
  localparam logic [LengthWidth-1:0] LenTop  = '1;
  localparam logic [LengthWidth-1:0] Len3    = LengthWidth'(3);

  logic                   comment_q, comment_d;
  logic [LineWidth-1:0]   line_q, line_d;
  logic [ColumnWidth-1:0] col_q, col_d, start_q, start_d;
  logic [LengthWidth-1:0] len_q, len_d;
  prog_t                  prog_q, prog_d, prog_init;
  logic [7:0]             c;

  assign prog_init = '{num: NStart, brk: BStart, curly: 1'b0, rgs: RStart,
                       first_pct: 1'b0, first_open: 2'd0, last_close: 2'd0,
                       node: NodeRoot, colon: 1'b0};

  // Fold case, step recognizers and counters
  always_comb begin
    c = (ch_i >= 8'h41 && ch_i <= 8'h5a) ? ch_i + 8'h20 : ch_i;
    comment_d = comment_q;
    line_d = line_q;
    col_d = col_q;
    start_d = start_q;
    len_d = len_q;
    prog_d = prog_q;
    ev_valid_o = 1'b0;
    ev_o = '{prog: prog_q, len_ge3: len_q >= Len3};
    ev_line_o = line_q;
    ev_col_o = start_q;
    ev_len_o = len_q;
    if (valid_i) begin
      if (!comment_q) begin
        if (is_tok(c)) begin
          if (len_q == '0) begin
            start_d = col_q;
            prog_d.first_pct = c == 8'h25;
            prog_d.first_open = (c == 8'h5b) ? 2'd1 : (c == 8'h7b) ? 2'd2 : 2'd0;
          end
          if (len_q != LenTop) len_d = len_q + 1'b1;
          prog_d.num = num_next(prog_q.num, c);
          prog_d.brk = brk_next(prog_q.brk, prog_q.curly, c);
          if (prog_q.brk == BStart) begin
            if (c == 8'h7b) prog_d.curly = 1'b1;
            else if (c == 8'h5b) prog_d.curly = 1'b0;
          end
          if (prog_q.rgs == RStart)
            prog_d.rgs = (c == 8'h72 || c == 8'h6c || c == 8'h69 || c == 8'h73 ||
                          c == 8'h62) ? RLet : RDead;
          else if (prog_q.rgs == RLet || prog_q.rgs == RDig)
            prog_d.rgs = is_digit(c) ? RDig : RDead;
          prog_d.node = trie_next(prog_q.node, c);
          prog_d.last_close = (c == 8'h5d) ? 2'd1 : (c == 8'h7d) ? 2'd2 : 2'd0;
          prog_d.colon = c == 8'h3a;
        end else begin
          ev_valid_o = len_q != '0;
          len_d = '0;
          start_d = '0;
          prog_d = prog_init;
        end
      end
      if (c == 8'h23) comment_d = 1'b1;
      if (c == 8'h0a) begin
        comment_d = 1'b0;
        if (line_q != LineTop) line_d = line_q + 1'b1;
        col_d = ColumnWidth'(1);
      end else if (col_q != ColTop) begin
        col_d = col_q + 1'b1;
      end
      if (text_end_i) begin
        comment_d = 1'b0;
        line_d = LineWidth'(1);
        col_d = ColumnWidth'(1);
        len_d = '0;
        start_d = '0;
        prog_d = prog_init;
      end
    end
  end

  // Hold recognizer and counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comment_q <= 1'b0;
      line_q <= LineWidth'(1);
      col_q <= ColumnWidth'(1);
      start_q <= '0;
      len_q <= '0;
      prog_q <= '{num: NStart, brk: BStart, curly: 1'b0, rgs: RStart,
                  first_pct: 1'b0, first_open: 2'd0, last_close: 2'd0,
                  node: NodeRoot, colon: 1'b0};
    end else begin
      comment_q <= comment_d;
      line_q <= line_d;
      col_q <= col_d;
      start_q <= start_d;
      len_q <= len_d;
      prog_q <= prog_d;
    end
  end
endmodule

// ===== src/atc_back.sv =====
`timescale 1ns / 1ps
module atc_back import atc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  ev_t        ev_i,
  output logic       ready_o,
  output logic       valid_o,
  input  logic       pop_i,
  output logic [4:0] type_o
);
  logic       valid_q;
  logic [4:0] type_q, type_d;
  prog_t      p;

  assign p = ev_i.prog;
  assign ready_o = !valid_q || pop_i;
  assign valid_o = valid_q;
  assign type_o = type_q;

  // Classify in priority order
  always_comb begin
    type_d = TypeUndef;
    if (p.first_pct) type_d = TypePreproc;
    else if (p.num == NZero || p.num == NDec) type_d = TypeDec;
    else if (p.num == NHex) type_d = TypeHex;
    else if (trie_kw(p.node)) type_d = TypeInstr;
    else if (p.rgs == RDig) type_d = TypeReg;
    else if (p.brk == BCDec) type_d = p.curly ? TypeCurly : TypeSquare;
    else if (p.brk == BCHex) type_d = (p.curly ? TypeCurly : TypeSquare) + 5'd1;
    else if (p.brk == BGDec) type_d = (p.curly ? TypeCurly : TypeSquare) + 5'd2;
    else if (p.brk == BAHex) type_d = (p.curly ? TypeCurly : TypeSquare) + 5'd3;
    else if (p.colon) type_d = TypeLabel;
    else if (ev_i.len_ge3 && p.first_open == 2'd1 && p.last_close == 2'd1)
      type_d = TypeLblRd;
    else if (ev_i.len_ge3 && p.first_open == 2'd2 && p.last_close == 2'd2)
      type_d = TypeLblWr;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else if (ready_o) valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) type_q <= type_d;
  end
endmodule

// ===== src/atc_checker.sv =====
`timescale 1ns / 1ps
`include "assembly_token_classifier_defines.svh"
module atc_checker #(
  parameter int unsigned LineWidth   = 20,
  parameter int unsigned ColumnWidth = 16,
  parameter int unsigned LengthWidth = 8
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   push,
  input logic                   full,
  input logic                   empty,
  input logic                   pop,
  input logic [4:0]             token_type_o,
  input logic [LineWidth-1:0]   token_line_o,
  input logic [ColumnWidth-1:0] token_column_o,
  input logic [LengthWidth-1:0] token_length_o
);
  `ATC_ASSERT(a_type_range, clk_i, rst_ni, empty || token_type_o <= 5'd16, "type out of range")
  `ATC_ASSERT(a_len_nz, clk_i, rst_ni, empty || token_length_o != '0, "zero length token")
  `ATC_ASSERT(a_pos_nz, clk_i, rst_ni, empty || (token_line_o != '0 && token_column_o != '0), "zero position")
  `ATC_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, !empty && $stable(token_type_o), "result dropped")
endmodule

bind assembly_token_classifier atc_checker #(
  .LineWidth(LineWidth), .ColumnWidth(ColumnWidth), .LengthWidth(LengthWidth)
) u_atc_checker (.*);

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import atc_pkg::*;

  // Expected token record
  typedef struct packed {
    logic [4:0]  kind;
    logic [19:0] line;
    logic [15:0] col;
    logic [7:0]  len;
  } tok_t;

  // Keyword list used by the predictor
  localparam int NumKw = 23;
  string kw_list [NumKw] = '{"hlt", "mov", "sum", "sub", "cmp", "call", "push", "pushb",
    "pushs", "pushi", "pushl", "pushr", "pop", "jmp", "je", "jl", "jb", "jne", "jle",
    "jbe", "ret", "int", "iret"};

  // Track tokens against the byte stream and hold expected results
  class token_scoreboard;
    tok_t pending[$];
    int   errors;
    bit   in_cmt;
    int   line_no, col_no;
    string text;
    int   start_col;

    function void clear();
      in_cmt = 0; line_no = 1; col_no = 1; text = ""; start_col = 0;
    endfunction

    function bit all_digits(string s, bit hex);
      if (s.len() == 0) return 0;
      for (int i = 0; i < s.len(); i++) begin
        if (!((s[i] >= "0" && s[i] <= "9") || (hex && s[i] >= "a" && s[i] <= "f")))
          return 0;
      end
      return 1;
    endfunction

    // Match "0x" followed by hex digits
    function bit hex_lit(string s);
      return s.len() > 2 && s.substr(0, 1) == "0x" && all_digits(s.substr(2, s.len()-1), 1);
    endfunction

    // Classify bracketed address forms; 0 if none
    function logic [4:0] addr_kind(string s);
      logic [4:0] base;
      byte cl;
      int n, k;
      string body;
      n = s.len();
      if (n < 3) return 0;
      if (s[0] == "{") begin base = 6; cl = "}"; end
      else if (s[0] == "[") begin base = 10; cl = "]"; end
      else return 0;
      k = -1;
      for (int i = 1; i < n; i++) if (s[i] == cl) begin k = i; break; end
      if (k < 2) return 0;
      if (!(k == n - 1 || k == n - 2)) return 0;
      body = s.substr(1, k - 1);
      if (k == n - 1) begin
        if (all_digits(body, 0)) return base;
        if (hex_lit(body)) return 5'(base + 1);
      end else begin
        if (s[n-1] == "g" && all_digits(body, 0)) return 5'(base + 2);
        if (s[n-1] == "a" && hex_lit(body)) return 5'(base + 3);
      end
      return 0;
    endfunction

    function logic [4:0] classify(string s);
      string t;
      int n;
      logic [4:0] a;
      n = s.len();
      if (s[0] == "%") return TypePreproc;
      t = (s[0] == "-") ? s.substr(1, n - 1) : s;
      if (n > 0 && s[0] == "-" && n == 1) t = "";
      if (all_digits(t, 0)) return TypeDec;
      if (hex_lit(t)) return TypeHex;
      foreach (kw_list[i]) if (s == kw_list[i]) return TypeInstr;
      if (n >= 2 && (s[0] == "r" || s[0] == "l" || s[0] == "i" || s[0] == "s" ||
          s[0] == "b") && all_digits(s.substr(1, n - 1), 0)) return TypeReg;
      a = addr_kind(s);
      if (a != 0) return a;
      if (s[n-1] == ":") return TypeLabel;
      if (n >= 3 && s[0] == "[" && s[n-1] == "]") return TypeLblRd;
      if (n >= 3 && s[0] == "{" && s[n-1] == "}") return TypeLblWr;
      return TypeUndef;
    endfunction

    function bit tok_char(byte c);
      return (c >= "a" && c <= "z") || (c >= "0" && c <= "9") || c == "%" || c == "$" ||
             c == ":" || c == "[" || c == "]" || c == "{" || c == "}" || c == "-";
    endfunction

    // Note one accepted byte
    function void note_byte(logic [7:0] raw, logic last);
      byte c;
      tok_t t;
      c = raw;
      if (raw >= 8'h41 && raw <= 8'h5a) c = raw + 8'h20;
      if (!in_cmt) begin
        if (tok_char(c)) begin
          if (text.len() == 0) start_col = col_no;
          text = {text, string'(c)};
        end else begin
          if (text.len() > 0) begin
            t.kind = classify(text);
            t.line = 20'(line_no);
            t.col = 16'(start_col);
            t.len = (text.len() > 255) ? 8'd255 : 8'(text.len());
            pending.insert(pending.size(), t);
          end
          text = "";
        end
      end
      if (c == "#") in_cmt = 1;
      if (c == 8'h0a) begin
        in_cmt = 0;
        if (line_no < 20'hFFFFF) line_no++;
        col_no = 1;
      end else if (col_no < 16'hFFFF) col_no++;
      if (last) clear();
    endfunction

    // Compare one popped result
    function void check(tok_t got);
      tok_t w;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected token %p", got);
        return;
      end
      w = pending.pop_front();
      if (got !== w) begin
        errors++;
        if (errors <= 10) $display("token mismatch: expected %p actual %p", w, got);
      end
    endfunction
  endclass

  logic        clk, rst_n, push, full, text_end, empty, pop;
  logic [7:0]  ch;
  logic [4:0]  token_type;
  logic [19:0] token_line;
  logic [15:0] token_column;
  logic [7:0]  token_length;
  token_scoreboard sb;

  assembly_token_classifier DUT (
    .clk_i(clk), .rst_ni(rst_n), .push(push), .full(full), .ch_i(ch),
    .text_end_i(text_end), .empty(empty), .pop(pop), .token_type_o(token_type),
    .token_line_o(token_line), .token_column_o(token_column), .token_length_o(token_length)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // Send one byte, holding it until the transfer; push stays high for back-to-back bytes
  task automatic send_byte(logic [7:0] c, logic last, bit gaps);
    int idle;
    idle = gaps ? $urandom_range(0, 16) : 0;
    if ($urandom_range(0, 3) == 0) idle = 0;
    @(negedge clk);
    if (idle > 0) begin
      push <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    push <= 1'b1; ch <= c; text_end <= last;
    do @(posedge clk); while (full);
    sb.note_byte(c, last);
  endtask

  task automatic send_text(string s, bit gaps);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0, gaps);
  endtask

  // Random word: a well-formed token of one class, or a run of random token characters
  function automatic string rand_word();
    string s, h, sgn, sfx, regs, pool;
    int k, n;
    regs = "rlisb";
    pool = "az09%$:[]{}-xAZ";
    sgn = "";
    sfx = "";
    if ($urandom_range(0, 1)) sgn = "-";
    n = $urandom_range(1, 4);
    h = "";
    for (int i = 0; i < n; i++) h = {h, string'(byte'($urandom_range(0, 1) ?
      $urandom_range(48, 57) : $urandom_range(97, 102)))};
    k = $urandom_range(0, 13);
    case (k)
      0: s = {"%", h};
      1: s = {sgn, $sformatf("%0d", $urandom_range(0, 99999))};
      2: s = {sgn, "0x", h};
      3: s = kw_list[$urandom_range(0, NumKw - 1)];
      4: s = {string'(regs[$urandom_range(0, 4)]), $sformatf("%0d", $urandom_range(0, 999))};
      5: begin
        if ($urandom_range(0, 1)) sfx = "g";
        s = {$sformatf("{%0d}", $urandom_range(0, 999)), sfx};
      end
      6: begin
        if ($urandom_range(0, 1)) sfx = "a";
        s = {"{0x", h, "}", sfx};
      end
      7: begin
        if ($urandom_range(0, 1)) sfx = "g";
        s = {$sformatf("[%0d]", $urandom_range(0, 999)), sfx};
      end
      8: begin
        if ($urandom_range(0, 1)) sfx = "a";
        s = {"[0x", h, "]", sfx};
      end
      9: s = {"lbl", h, ":"};
      10: s = {"[", h, "]"};
      11: s = {"{", h, "$}"};
      12: begin
        sfx = "x";
        if ($urandom_range(0, 1)) sfx = "SHR";
        s = {"Pu", sfx, "::"};
      end
      default: begin
        s = "";
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) s = {s, string'(pool[$urandom_range(0, 14)])};
      end
    endcase
    return s;
  endfunction

  function automatic byte rand_sep();
    case ($urandom_range(0, 7))
      0: return 8'h0a;
      1: return 8'h09;
      2: return 8'h2c;
      3: return byte'($urandom_range(128, 255));
      4: return byte'($urandom_range(0, 31));
      default: return 8'h20;
    endcase
  endfunction

  // Pop results with random stalls
  initial begin
    int idle;
    pop = 1'b0;
    @(posedge rst_n);
    forever begin
      idle = $urandom_range(0, 16);
      if ($urandom_range(0, 3) == 0) idle = 0;
      @(negedge clk);
      if (idle > 0) begin
        pop <= 1'b0;
        repeat (idle) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check('{token_type, token_line, token_column, token_length});
    end
  end

  // Stimulus and end of run
  initial begin
    int sent, tmo;
    string w;
    sb = new();
    sb.clear();
    push = 1'b0; ch = 8'h00; text_end = 1'b0;
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: classes, comment, case folding, separators, text end drop
    send_text("%def 12 -0 0x1F -0xab PUSHR iret r7 {3} {0xa} {5}g {0xf}a ", 0);
    send_text("[9] [0x0] [1]g [0x2]a lab: [x] {yz} - q$ #cmt x\n", 1);
    send_byte(8'hff, 1'b0, 0);
    send_byte(8'h80, 1'b0, 1);
    send_byte(8'h7f, 1'b0, 1);
    send_text("ab", 1);
    send_byte(8'h20, 1'b1, 0);
    send_text("open", 0);
    send_byte("z", 1'b1, 1);
    // Over-long token saturates the length
    for (int i = 0; i < 300; i++) send_byte("9", 1'b0, 0);
    send_byte(8'h0a, 1'b0, 0);

    // Random text
    sent = 0;
    while (sent < 1400) begin
      if ($urandom_range(0, 15) == 0) begin
        send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 40) == 0, 1);
        sent++;
      end else begin
        w = rand_word();
        if ($urandom_range(0, 20) == 0) w = {"#", w};
        send_text(w, 1);
        send_byte(rand_sep(), $urandom_range(0, 60) == 0, 1);
        sent += w.len() + 1;
      end
    end
    send_byte(8'h20, 1'b1, 1);
    @(negedge clk);
    push <= 1'b0;

    tmo = 0;
    while (sb.pending.size() != 0 && tmo < 100000) begin
      @(posedge clk);
      tmo++;
    end
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end
endmodule
